@@ hdl/spvc_pkg.sv @@
// ----------------------------------------------------------------------------
// Sprite post vertical clip package
// Shared types and constants for the post projection, divider chain and
// draw command stages.
// ----------------------------------------------------------------------------
package spvc_pkg;

  // Register indexes on the configuration port (byte address 4 * index).
  localparam int unsigned CfgAddrW = 4;

  typedef enum logic [1:0] {
    REG_VIEW_HEIGHT   = 2'd0,
    REG_ROW_PITCH     = 2'd1,
    REG_BOUNCE_OFFSET = 2'd2,
    REG_BOUNCE_ENABLE = 2'd3
  } spvc_reg_e;

  typedef enum logic [1:0] {
    KIND_PLAIN   = 2'd0,
    KIND_SHADED  = 2'd1,
    KIND_CLOAKED = 2'd2
  } spvc_kind_e;

  // Texture step numerator 4194304 = 1 << 22, so the quotient has 23 bits.
  localparam int unsigned QuoW      = 23;
  localparam int unsigned DivStages = QuoW;
  localparam logic [QuoW-1:0] TexNumer = 23'h400000;

  typedef struct packed {
    logic [9:0]  view_height;
    logic [11:0] row_pitch;
    logic [31:0] bounce_offset;
    logic        bounce_enable;
  } spvc_cfg_t;

  typedef struct packed {
    logic [11:0] post_height;
    logic [7:0]  end_word;
    logic [7:0]  start_word;
    logic [15:0] source_word;
    logic [19:0] column_base;
    logic        shaded;
    logic        cloaked;
  } spvc_in_t;

  typedef struct packed {
    logic        draw;
    logic [1:0]  draw_kind;
    logic [9:0]  top_row;
    logic [10:0] row_count;
    logic [22:0] tex_step;
    logic [31:0] tex_start;
    logic [31:0] dest_offset;
    logic [15:0] source_offset;
  } spvc_out_t;

  // Everything a post carries alongside the divider.
  typedef struct packed {
    logic        draw;
    logic [1:0]  kind;
    logic [9:0]  top_row;
    logic [10:0] row_count;
    logic [16:0] clip_rows;
    logic [19:0] base;
    logic [15:0] source_offset;
    logic [11:0] divisor;
  } spvc_work_t;

  // Partial state of the restoring division handed from cell to cell.
  typedef struct packed {
    logic [11:0]     rem;
    logic [QuoW-1:0] num;
    logic [QuoW-1:0] quo;
  } spvc_div_t;

endpackage

@@ hdl/spvc_front.sv @@
// ----------------------------------------------------------------------------
// Sprite post projection
// Projects the post's top and bottom rows in 16.16 fixed point, clips them
// to the view and seeds the divider chain. Three registered stages.
// ----------------------------------------------------------------------------
module spvc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  spvc_pkg::spvc_cfg_t cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  spvc_pkg::spvc_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output spvc_pkg::spvc_work_t out_work_o,
  output spvc_pkg::spvc_div_t  out_div_o
);
  import spvc_pkg::*;

  // Stage A: top offset and the two row products.
  logic        a_valid_q;
  logic        a_nodraw_q;
  logic [1:0]  a_kind_q;
  logic [11:0] a_h_q;
  logic [15:0] a_src_q;
  logic [19:0] a_base_q;
  logic [31:0] a_top_off_q;
  logic [28:0] a_p_top_q, a_p_bot_q;
  // Stage B: unclipped top and bottom rows.
  logic        b_valid_q;
  logic        b_nodraw_q;
  logic [1:0]  b_kind_q;
  logic [11:0] b_h_q;
  logic [15:0] b_src_q;
  logic [19:0] b_base_q;
  logic [15:0] b_yl_q, b_yh_q;
  // Stage C: clipped command, seed of the divider.
  logic        c_valid_q;
  spvc_work_t  c_work_q;

  logic        a_ready, b_ready, c_ready;
  logic [6:0]  end_row, start_row;
  logic [21:0] sstep;
  logic [31:0] top_off_d, half_bounce;
  logic [31:0] yl_sum, yh_sum;
  logic [1:0]  kind_d;
  logic signed [16:0] yl_s, yh_s, vh_s, yh_c, yl_c, span;
  logic [16:0] clip_d;
  logic        draw_d;

  assign c_ready    = !c_valid_q || out_ready_i;
  assign b_ready    = !b_valid_q || c_ready;
  assign a_ready    = !a_valid_q || b_ready;
  assign in_ready_o = a_ready;

  always_comb begin
    end_row     = in_data_i.end_word[7:1];
    start_row   = in_data_i.start_word[7:1];
    sstep       = {in_data_i.post_height, 10'd0};
    half_bounce = {cfg_i.bounce_offset[31], cfg_i.bounce_offset[31:1]};
    top_off_d   = {7'd0, cfg_i.view_height, 15'd0} - {5'd0, in_data_i.post_height, 15'd0};
    if (cfg_i.bounce_enable) begin
      top_off_d = top_off_d + half_bounce;
    end
    if (!in_data_i.shaded) begin
      kind_d = KIND_PLAIN;
    end else if (in_data_i.cloaked) begin
      kind_d = KIND_CLOAKED;
    end else begin
      kind_d = KIND_SHADED;
    end
  end

  // The bottom is taken straight from the end row: top + step * (end - start)
  // wraps to the same value as top_off + step * end.
  assign yl_sum = a_top_off_q + {3'd0, a_p_top_q} + 32'h0000_FFFF;
  assign yh_sum = a_top_off_q + {3'd0, a_p_bot_q} - 32'd1;

  always_comb begin
    yl_s   = {b_yl_q[15], b_yl_q};
    yh_s   = {b_yh_q[15], b_yh_q};
    vh_s   = {7'd0, cfg_i.view_height};
    yh_c   = (yh_s >= vh_s) ? (vh_s - 17'sd1) : yh_s;
    yl_c   = yl_s[16] ? 17'sd0 : yl_s;
    clip_d = yl_s[16] ? (17'd0 - yl_s) : 17'd0;
    span   = yh_c - yl_c;
    draw_d = !b_nodraw_q && !(yl_c > yh_c);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      if (a_ready) a_valid_q <= in_valid_i;
      if (b_ready) b_valid_q <= a_valid_q;
      if (c_ready) c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && in_valid_i) begin
      a_nodraw_q  <= (end_row == 7'd0) || (in_data_i.post_height == 12'd0);
      a_kind_q    <= kind_d;
      a_h_q       <= in_data_i.post_height;
      a_src_q     <= in_data_i.source_word + {9'd0, start_row};
      a_base_q    <= in_data_i.column_base;
      a_top_off_q <= top_off_d;
      a_p_top_q   <= {7'd0, sstep} * {22'd0, start_row};
      a_p_bot_q   <= {7'd0, sstep} * {22'd0, end_row};
    end
    if (b_ready && a_valid_q) begin
      b_nodraw_q <= a_nodraw_q;
      b_kind_q   <= a_kind_q;
      b_h_q      <= a_h_q;
      b_src_q    <= a_src_q;
      b_base_q   <= a_base_q;
      b_yl_q     <= yl_sum[31:16];
      b_yh_q     <= yh_sum[31:16];
    end
    if (c_ready && b_valid_q) begin
      c_work_q.draw          <= draw_d;
      c_work_q.kind          <= b_kind_q;
      c_work_q.top_row       <= yl_c[9:0];
      c_work_q.row_count     <= span[10:0] + 11'd1;
      c_work_q.clip_rows     <= clip_d;
      c_work_q.base          <= b_base_q;
      c_work_q.source_offset <= b_src_q;
      c_work_q.divisor       <= b_h_q;
    end
  end

  assign out_valid_o    = c_valid_q;
  assign out_work_o     = c_work_q;
  assign out_div_o.rem  = 12'd0;
  assign out_div_o.num  = TexNumer;
  assign out_div_o.quo  = '0;

endmodule

@@ hdl/spvc_div_cell.sv @@
// ----------------------------------------------------------------------------
// Divider cell
// One restoring division step: shifts in one numerator bit, trial-subtracts
// the divisor and appends one quotient bit. The post rides along.
// ----------------------------------------------------------------------------
module spvc_div_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  spvc_pkg::spvc_work_t in_work_i,
  input  spvc_pkg::spvc_div_t  in_div_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output spvc_pkg::spvc_work_t out_work_o,
  output spvc_pkg::spvc_div_t  out_div_o
);
  import spvc_pkg::*;

  logic       valid_q;
  spvc_work_t work_q;
  spvc_div_t  div_q, div_d;
  logic [12:0] trial, diff;
  logic        fits;

  assign in_ready_o = !valid_q || out_ready_i;

  // A zero divisor only occurs on posts that are not drawn.
  always_comb begin
    trial     = {in_div_i.rem, in_div_i.num[QuoW-1]};
    diff      = trial - {1'b0, in_work_i.divisor};
    fits      = (trial >= {1'b0, in_work_i.divisor});
    div_d.rem = fits ? diff[11:0] : trial[11:0];
    div_d.num = {in_div_i.num[QuoW-2:0], 1'b0};
    div_d.quo = {in_div_i.quo[QuoW-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      work_q <= in_work_i;
      div_q  <= div_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_work_o  = work_q;
  assign out_div_o   = div_q;

endmodule

@@ hdl/spvc_back.sv @@
// ----------------------------------------------------------------------------
// Draw command stage
// Forms the starting texture fraction and destination offset, and holds the
// finished command in the output register.
// ----------------------------------------------------------------------------
module spvc_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  spvc_pkg::spvc_cfg_t  cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  spvc_pkg::spvc_work_t in_work_i,
  input  spvc_pkg::spvc_div_t  in_div_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output spvc_pkg::spvc_out_t  out_data_o
);
  import spvc_pkg::*;

  logic        m_valid_q;
  spvc_work_t  m_work_q;
  logic [QuoW-1:0] m_step_q;
  logic [31:0] m_frac_q;
  logic [21:0] m_rowp_q;
  logic        o_valid_q;
  spvc_out_t   o_data_q, o_data_d;
  logic        m_ready;
  logic [39:0] frac_full;
  logic [31:0] dest;

  assign in_ready_o = !m_valid_q || m_ready;
  assign m_ready    = !o_valid_q || out_ready_i;

  assign frac_full = {17'd0, in_div_i.quo} * {23'd0, in_work_i.clip_rows};
  assign dest      = {12'd0, m_work_q.base} + {10'd0, m_rowp_q};

  // A post that is not drawn reports zero in every field.
  always_comb begin
    o_data_d.draw          = m_work_q.draw;
    o_data_d.draw_kind     = m_work_q.kind;
    o_data_d.top_row       = m_work_q.top_row;
    o_data_d.row_count     = m_work_q.row_count;
    o_data_d.tex_step      = m_step_q;
    o_data_d.tex_start     = m_frac_q;
    o_data_d.dest_offset   = dest;
    o_data_d.source_offset = m_work_q.source_offset;
    if (!m_work_q.draw) begin
      o_data_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) m_valid_q <= in_valid_i;
      if (m_ready)    o_valid_q <= m_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      m_work_q <= in_work_i;
      m_step_q <= in_div_i.quo;
      m_frac_q <= frac_full[31:0];
      m_rowp_q <= {10'd0, cfg_i.row_pitch} * {12'd0, in_work_i.top_row};
    end
    if (m_ready && m_valid_q) begin
      o_data_q <= o_data_d;
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_data_o  = o_data_q;

endmodule

@@ hdl/sprite_post_vertical_clip_core.sv @@
// ----------------------------------------------------------------------------
// Sprite post vertical clip core
// Turns one opaque post of a scaled sprite column into a column-draw command.
// ----------------------------------------------------------------------------
// The block takes one post beat per clock while the output is not stalled and
// returns one command beat per post, in order, through the projection and
// clipping stages, 23 divider cells (one quotient bit of the texture step
// each) and the stages that form the texture fraction, the destination
// offset and the output register. Every stage holds its own beat, so a
// stall at the output fills the pipeline's empty places before the input
// is held off. Registers are written over the APB port at byte address
// 4 * index and should only change while no post is in flight.
module sprite_post_vertical_clip_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [spvc_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  spvc_pkg::spvc_in_t           in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output spvc_pkg::spvc_out_t          out_data_o
);
  import spvc_pkg::*;

  spvc_cfg_t  cfg_q;
  spvc_reg_e  reg_sel;
  logic       wr_en;

  logic       valid_c [DivStages+1];
  logic       ready_c [DivStages+1];
  spvc_work_t work_c  [DivStages+1];
  spvc_div_t  div_c   [DivStages+1];

  assign pready  = 1'b1;
  assign reg_sel = spvc_reg_e'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.view_height   <= 10'd200;
      cfg_q.row_pitch     <= 12'd320;
      cfg_q.bounce_offset <= 32'd0;
      cfg_q.bounce_enable <= 1'b0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_VIEW_HEIGHT:   cfg_q.view_height   <= pwdata[9:0];
        REG_ROW_PITCH:     cfg_q.row_pitch     <= pwdata[11:0];
        REG_BOUNCE_OFFSET: cfg_q.bounce_offset <= pwdata;
        REG_BOUNCE_ENABLE: cfg_q.bounce_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_VIEW_HEIGHT:   prdata = {22'd0, cfg_q.view_height};
      REG_ROW_PITCH:     prdata = {20'd0, cfg_q.row_pitch};
      REG_BOUNCE_OFFSET: prdata = cfg_q.bounce_offset;
      REG_BOUNCE_ENABLE: prdata = {31'd0, cfg_q.bounce_enable};
      default:           prdata = 32'd0;
    endcase
  end

  spvc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (valid_c[0]),
    .out_ready_i (ready_c[0]),
    .out_work_o  (work_c[0]),
    .out_div_o   (div_c[0])
  );

  for (genvar i = 0; i < DivStages; i++) begin : g_cell
    spvc_div_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (valid_c[i]),
      .in_ready_o  (ready_c[i]),
      .in_work_i   (work_c[i]),
      .in_div_i    (div_c[i]),
      .out_valid_o (valid_c[i+1]),
      .out_ready_i (ready_c[i+1]),
      .out_work_o  (work_c[i+1]),
      .out_div_o   (div_c[i+1])
    );
  end

  spvc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (valid_c[DivStages]),
    .in_ready_o  (ready_c[DivStages]),
    .in_work_i   (work_c[DivStages]),
    .in_div_i    (div_c[DivStages]),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ hdl/spvc_checker.sv @@
// ----------------------------------------------------------------------------
// Sprite post vertical clip checker
// Port-level assertions on the command channel, bound to the core.
// ----------------------------------------------------------------------------
module spvc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input spvc_pkg::spvc_out_t out_data_o
);
  import spvc_pkg::*;

  // A stalled command beat stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("command beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("command beat changed while stalled");

  // A post that is not drawn carries nothing else.
  a_nodraw_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.draw |->
      out_data_o.draw_kind == KIND_PLAIN && out_data_o.row_count == 11'd0 &&
      out_data_o.tex_step == 23'd0 && out_data_o.tex_start == 32'd0 &&
      out_data_o.dest_offset == 32'd0 && out_data_o.source_offset == 16'd0 &&
      out_data_o.top_row == 10'd0)
    else $error("undrawn post carries nonzero fields");

  // A drawn post covers at least one row and ends inside the largest view range.
  a_draw_rows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.draw |->
      out_data_o.row_count != 11'd0 &&
      ({1'b0, out_data_o.top_row} + out_data_o.row_count) <= 11'd1023)
    else $error("drawn post has an impossible row range");

  // A drawn post always has a texture step: its height was nonzero.
  a_draw_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.draw |->
      out_data_o.tex_step != 23'd0 &&
      (out_data_o.draw_kind == KIND_PLAIN || out_data_o.draw_kind == KIND_SHADED ||
       out_data_o.draw_kind == KIND_CLOAKED))
    else $error("drawn post without texture step or with a bad routine");

endmodule

bind sprite_post_vertical_clip_core spvc_checker u_spvc_checker (.*);

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite post vertical clip core testbench
// Posts go in on a valid/ready channel and every draw command that comes out
// is compared, field by field, with an in-order queue of predicted commands.
// The register set is swept over APB between bursts, including the
// extremes, while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import spvc_pkg::*;

  localparam int StallLimit    = 5000;
  localparam int SegmentPosts  = 100;
  localparam int TailCycles    = 40;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;
  logic                post_valid;
  logic                post_ready;
  spvc_in_t            post_data;
  logic                cmd_valid;
  logic                cmd_ready;
  spvc_out_t           cmd_data;

  spvc_cfg_t           clip_cfg;
  spvc_out_t           expected_cmds[$];
  int                  error_count = 0;
  int                  send_idle_pct = 0;
  int                  recv_idle_pct = 0;
  int                  recv_hold = 0;
  int                  quiet_cycles = 0;

  sprite_post_vertical_clip_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (post_valid),
    .in_ready_o  (post_ready),
    .in_data_i   (post_data),
    .out_valid_o (cmd_valid),
    .out_ready_i (cmd_ready),
    .out_data_o  (cmd_data)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Projects one post against the current register set and clips it to the view.
  function automatic spvc_out_t project_post(input spvc_in_t p);
    spvc_out_t   r;
    logic [31:0] h, end_row, start_row, step, sstep, top_off, len, topscr, botscr, frac;
    int          yl, yh;
    r = '0;
    h = 32'(p.post_height);
    end_row = 32'(p.end_word >> 1);
    start_row = 32'(p.start_word >> 1);
    if (end_row == 32'd0 || h == 32'd0) return r;
    step = 32'd4194304 / h;
    sstep = h << 10;
    top_off = (32'(clip_cfg.view_height) << 15) - (h << 15);
    if (clip_cfg.bounce_enable) begin
      top_off = top_off + 32'($signed(clip_cfg.bounce_offset) >>> 1);
    end
    len = end_row - start_row;
    topscr = top_off + sstep * start_row;
    botscr = topscr + sstep * len;
    yl = $signed(topscr + 32'h0000_FFFF) >>> 16;
    yh = $signed(botscr - 32'd1) >>> 16;
    if (yh >= int'(clip_cfg.view_height)) yh = int'(clip_cfg.view_height) - 1;
    frac = 32'd0;
    if (yl < 0) begin
      frac = step * 32'(-yl);
      yl = 0;
    end
    if (yl > yh) return r;
    r.draw = 1'b1;
    r.draw_kind = p.shaded ? (p.cloaked ? KIND_CLOAKED : KIND_SHADED) : KIND_PLAIN;
    r.top_row = yl[9:0];
    r.row_count = 11'(yh - yl + 1);
    r.tex_step = step[22:0];
    r.tex_start = frac;
    r.dest_offset = 32'(p.column_base) + 32'(clip_cfg.row_pitch) * 32'(yl);
    r.source_offset = p.source_word + 16'(start_row);
    return r;
  endfunction

  function automatic spvc_in_t make_post(input logic [11:0] h, input logic [7:0] end_w,
                                         input logic [7:0] start_w, input logic [15:0] src,
                                         input logic [19:0] base, input logic sh,
                                         input logic cl);
    spvc_in_t p;
    p.post_height = h;
    p.end_word = end_w;
    p.start_word = start_w;
    p.source_word = src;
    p.column_base = base;
    p.shaded = sh;
    p.cloaked = cl;
    return p;
  endfunction

  // Mostly well-formed posts sized to the view, then noise and broken posts.
  function automatic spvc_in_t random_post();
    spvc_in_t p;
    int       roll, s_row, e_row, hi;
    roll = int'($urandom_range(99));
    p.source_word = 16'($urandom);
    p.column_base = 20'($urandom);
    p.shaded = 1'($urandom);
    p.cloaked = 1'($urandom);
    hi = 2 * int'(clip_cfg.view_height) + 64;
    if (hi > 4095) hi = 4095;
    p.post_height = 12'($urandom_range(hi, 1));
    if (roll < 75) begin
      s_row = int'($urandom_range(62));
      e_row = int'($urandom_range(64, s_row + 1));
      p.start_word = 8'(2 * s_row) | 8'($urandom_range(1));
      p.end_word = 8'(2 * e_row) | 8'($urandom_range(1));
    end else if (roll < 90) begin
      p.post_height = 12'($urandom);
      p.start_word = 8'($urandom);
      p.end_word = 8'($urandom);
    end else begin
      e_row = int'($urandom_range(120, 2));
      p.end_word = 8'(e_row);
      p.start_word = 8'($urandom_range(e_row - 1));
      case ($urandom_range(2))
        0: p.post_height = '0;
        1: p.end_word = 8'($urandom_range(1));
        default: p.start_word = 8'($urandom_range(255, e_row + 1));
      endcase
    end
    return p;
  endfunction

  // Offers one post, possibly after a random gap, and records its command once taken.
  task automatic send_post(input spvc_in_t p);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      post_valid <= 1'b0;
      @(negedge clk_i);
    end
    post_valid <= 1'b1;
    post_data <= p;
    @(posedge clk_i);
    while (!post_ready) @(posedge clk_i);
    expected_cmds.push_back(project_post(p));
  endtask

  task automatic drain_posts();
    @(negedge clk_i);
    post_valid <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input spvc_reg_e idx, input logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      REG_VIEW_HEIGHT:   clip_cfg.view_height = value[9:0];
      REG_ROW_PITCH:     clip_cfg.row_pitch = value[11:0];
      REG_BOUNCE_OFFSET: clip_cfg.bounce_offset = value;
      default:           clip_cfg.bounce_enable = value[0];
    endcase
  endtask

  task automatic apply_setting(input logic [9:0] vh, input logic [11:0] pitch,
                               input logic [31:0] bounce, input logic enable);
    drain_posts();
    write_reg(REG_VIEW_HEIGHT, 32'(vh));
    write_reg(REG_ROW_PITCH, 32'(pitch));
    write_reg(REG_BOUNCE_OFFSET, bounce);
    write_reg(REG_BOUNCE_ENABLE, 32'(enable));
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_directed_posts();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_post(make_post(12'd64, 8'd128, 8'd0, 16'h0100, 20'h00400, 1'b0, 1'b0));
    send_post(make_post(12'd0, 8'd128, 8'd0, 16'h0100, 20'h00400, 1'b0, 1'b0));
    send_post(make_post(12'd64, 8'd0, 8'd0, 16'h0100, 20'h00400, 1'b0, 1'b0));
    send_post(make_post(12'd64, 8'd1, 8'd0, 16'h0100, 20'h00400, 1'b1, 1'b0));
    send_post(make_post(12'd1, 8'd128, 8'd0, 16'h0200, 20'h01000, 1'b0, 1'b0));
    send_post(make_post(12'd4095, 8'd255, 8'd0, 16'hFFFF, 20'hFFFFF, 1'b1, 1'b1));
    send_post(make_post(12'hFFF, 8'hFF, 8'hFF, 16'hFFFF, 20'hFFFFF, 1'b1, 1'b1));
    send_post(make_post(12'd0, 8'd0, 8'd0, 16'h0000, 20'h00000, 1'b0, 1'b0));
    // Start after end: the length wraps negative.
    send_post(make_post(12'd64, 8'd20, 8'd200, 16'h0010, 20'h00020, 1'b0, 1'b0));
    send_post(make_post(12'd64, 8'd100, 8'd100, 16'h0010, 20'h00020, 1'b0, 1'b0));
    // Taller than the view, so the top is clipped and a texture fraction appears.
    send_post(make_post(12'd400, 8'd128, 8'd2, 16'h0040, 20'h12345, 1'b1, 1'b0));
    send_post(make_post(12'd64, 8'd255, 8'd252, 16'hFFFF, 20'hFFFFF, 1'b0, 1'b1));
    send_post(make_post(12'd128, 8'd64, 8'd0, 16'h1234, 20'hABCDE, 1'b0, 1'b1));
    send_post(make_post(12'd128, 8'd64, 8'd0, 16'h1234, 20'hABCDE, 1'b1, 1'b0));
    send_post(make_post(12'd128, 8'd64, 8'd0, 16'h1234, 20'hABCDE, 1'b1, 1'b1));
    send_post(make_post(12'd200, 8'd255, 8'd254, 16'h8000, 20'h80000, 1'b0, 1'b0));
  endtask

  // The receiver stops for a long stretch while posts keep coming, so the
  // pipeline fills and the input has to be held off.
  task automatic test_output_backpressure();
    drain_posts();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    recv_hold = 300;
    repeat (120) send_post(random_post());
  endtask

  task automatic choose_setting(input int k);
    logic [31:0] bounce;
    int          b;
    b = int'($urandom_range(32'h0100_0000)) - 32'h0080_0000;
    bounce = ($urandom_range(5) == 0) ? $urandom : 32'(b);
    case (k)
      0: apply_setting(10'd200, 12'd320, 32'h0000_0000, 1'b0);
      1: apply_setting(10'd1023, 12'd4095, 32'h8000_0000, 1'b1);
      2: apply_setting(10'd1, 12'd1, 32'h7FFF_FFFF, 1'b1);
      // A zero view height clips every post away.
      3: apply_setting(10'd0, 12'($urandom_range(4095, 1)), bounce, 1'b1);
      4: apply_setting(10'($urandom_range(1023, 1)), 12'($urandom_range(4095, 1)),
                       32'hFFFF_FFFF, 1'b1);
      default: apply_setting(10'($urandom_range(1023, 1)), 12'($urandom_range(4095, 1)),
                             bounce, 1'($urandom));
    endcase
  endtask

  task automatic test_random_traffic(input int send_idle, input int recv_idle);
    for (int k = 0; k < 6; k++) begin
      choose_setting(k);
      send_idle_pct = send_idle;
      recv_idle_pct = recv_idle;
      repeat (SegmentPosts) send_post(random_post());
    end
  endtask

  always @(negedge clk_i) begin
    if (recv_hold != 0) begin
      recv_hold = recv_hold - 1;
      cmd_ready <= 1'b0;
    end else begin
      cmd_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin : check_commands
    spvc_out_t want;
    if (rst_ni && cmd_valid && cmd_ready) begin
      if (expected_cmds.size() == 0) begin
        $error("draw command beat with no post outstanding");
        error_count++;
      end else begin
        want = expected_cmds.pop_front();
        check_field("draw", 32'(want.draw), 32'(cmd_data.draw));
        check_field("draw_kind", 32'(want.draw_kind), 32'(cmd_data.draw_kind));
        check_field("top_row", 32'(want.top_row), 32'(cmd_data.top_row));
        check_field("row_count", 32'(want.row_count), 32'(cmd_data.row_count));
        check_field("tex_step", 32'(want.tex_step), 32'(cmd_data.tex_step));
        check_field("tex_start", want.tex_start, cmd_data.tex_start);
        check_field("dest_offset", want.dest_offset, cmd_data.dest_offset);
        check_field("source_offset", 32'(want.source_offset), 32'(cmd_data.source_offset));
      end
    end
  end

  // Ends the run if no beat moves on any port for too long.
  always @(posedge clk_i) begin
    if ((post_valid && post_ready) || (cmd_valid && cmd_ready) ||
        (psel && penable && pwrite && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    post_valid = 1'b0;
    post_data = '0;
    cmd_ready = 1'b0;
    clip_cfg.view_height = 10'd200;
    clip_cfg.row_pitch = 12'd320;
    clip_cfg.bounce_offset = 32'd0;
    clip_cfg.bounce_enable = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_posts();
    test_output_backpressure();
    test_random_traffic(24, 85);
    test_random_traffic(85, 24);
    test_random_traffic(0, 0);

    drain_posts();
    repeat (TailCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
